// ----- rtl/cioc_pkg.sv -----
// ----------------------------------------------------------------------------
// cioc_pkg
// Types and constants shared by the console I/O port controller files.
// ----------------------------------------------------------------------------
package cioc_pkg;

  typedef enum logic [1:0] {
    OP_CTRL_WR = 2'd0,
    OP_PORT_RD = 2'd1,
    OP_HH_RD   = 2'd2,
    OP_HH_WR   = 2'd3
  } opcode_t;

  localparam logic [1:0] KIND_HOME     = 2'd0;
  localparam logic [1:0] KIND_HANDHELD = 2'd1;

  localparam logic [1:0] CFG_TERRITORY = 2'd0;
  localparam logic [1:0] CFG_KIND      = 2'd1;
  localparam logic [1:0] CFG_PADDLE    = 2'd2;
  localparam logic [1:0] CFG_NTSC      = 2'd3;

  localparam logic [7:0] HH_INPUT  = 8'd0;
  localparam logic [7:0] HH_PDATA  = 8'd1;
  localparam logic [7:0] HH_DDIR   = 8'd2;
  localparam logic [7:0] HH_TXBUF  = 8'd3;
  localparam logic [7:0] HH_RXBUF  = 8'd4;
  localparam logic [7:0] HH_SCTRL  = 8'd5;
  localparam logic [7:0] HH_STEREO = 8'd6;

  localparam logic [7:0] PIN_CONTROL_RST = 8'hFF;
  localparam logic [7:0] PDATA_RST       = 8'h7F;
  localparam logic [7:0] DDIR_RST        = 8'hFF;
  localparam logic [7:0] TXBUF_RST       = 8'h00;
  localparam logic [7:0] RXBUF_RST       = 8'hFF;
  localparam logic [7:0] SCTRL_RST       = 8'h00;
  localparam logic [7:0] SCTRL_MASK      = 8'hF8;
  localparam logic [7:0] BYTE_ONES       = 8'hFF;

  typedef struct packed {
    logic       export_machine;
    logic [1:0] console_kind;
    logic       paddle_enable;
    logic       ntsc_display;
  } cfg_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] port_offset;
    logic [7:0] write_data;
    logic [5:0] pad_one;
    logic [5:0] pad_two;
    logic [1:0] system_keys;
    logic [7:0] paddle_position;
    logic       io_disabled;
    logic [7:0] open_bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       th_rising;
    logic       stereo_write;
    logic [7:0] stereo_value;
  } out_item_t;

endpackage

// ----- rtl/cioc_if.sv -----
// ----------------------------------------------------------------------------
// cioc_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface cioc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] port_offset;
  logic [7:0] write_data;
  logic [5:0] pad_one;
  logic [5:0] pad_two;
  logic [1:0] system_keys;
  logic [7:0] paddle_position;
  logic       io_disabled;
  logic [7:0] open_bus_byte;

  modport source (
    output valid, opcode, port_offset, write_data, pad_one, pad_two,
           system_keys, paddle_position, io_disabled, open_bus_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, port_offset, write_data, pad_one, pad_two,
           system_keys, paddle_position, io_disabled, open_bus_byte,
    output ready
  );
endinterface

interface cioc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       th_rising;
  logic       stereo_write;
  logic [7:0] stereo_value;

  modport source (
    output valid, read_data, th_rising, stereo_write, stereo_value,
    input  ready
  );
  modport sink (
    input  valid, read_data, th_rising, stereo_write, stereo_value,
    output ready
  );
endinterface

// ----- rtl/cioc_regs.sv -----
// ----------------------------------------------------------------------------
// cioc_regs
// APB configuration registers: territory, console kind, paddle, display.
// ----------------------------------------------------------------------------
module cioc_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cioc_pkg::cfg_t cfg
);
  import cioc_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.export_machine <= 1'b1;
      cfg.console_kind   <= KIND_HOME;
      cfg.paddle_enable  <= 1'b0;
      cfg.ntsc_display   <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        CFG_TERRITORY: cfg.export_machine <= pwdata[0];
        CFG_KIND:      cfg.console_kind   <= pwdata[1:0];
        CFG_PADDLE:    cfg.paddle_enable  <= pwdata[0];
        CFG_NTSC:      cfg.ntsc_display   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      CFG_TERRITORY: prdata[0]   = cfg.export_machine;
      CFG_KIND:      prdata[1:0] = cfg.console_kind;
      CFG_PADDLE:    prdata[0]   = cfg.paddle_enable;
      CFG_NTSC:      prdata[0]   = cfg.ntsc_display;
      default: ;
    endcase
  end

endmodule

// ----- rtl/cioc_datapath.sv -----
// ----------------------------------------------------------------------------
// cioc_datapath
// Pin, paddle and handheld register state with the access decode.
// ----------------------------------------------------------------------------
module cioc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cioc_pkg::cfg_t       cfg,
  input  cioc_pkg::in_item_t   item,
  input  logic                 commit,
  output cioc_pkg::out_item_t  result
);
  import cioc_pkg::*;

  logic [7:0] pin_control,     pin_control_next;
  logic       paddle_phase,    paddle_phase_next;
  logic [7:0] parallel_data,   parallel_data_next;
  logic [7:0] data_direction,  data_direction_next;
  logic [7:0] transmit_buffer, transmit_buffer_next;
  logic [7:0] receive_buffer;
  logic [7:0] serial_control,  serial_control_next;

  logic       exp_mode;
  logic       is_gg;
  logic       is_sms;
  logic [7:0] hh_par;
  logic [7:0] hh_rd;
  logic [7:0] port_rd;
  logic       phase_new;

  function automatic logic lvl(input logic [7:0] ctl, input logic [1:0] n,
                               input logic ex);
    lvl = ctl[n] | (ex & ctl[{1'b1, n}]);
  endfunction

  assign exp_mode = cfg.export_machine;
  assign is_gg    = (cfg.console_kind == KIND_HANDHELD);
  assign is_sms   = (cfg.console_kind == KIND_HOME);
  assign hh_par   = {parallel_data[7], data_direction[6:0] | parallel_data[6:0]};

  always_comb begin
    unique case (item.port_offset)
      HH_INPUT: hh_rd = {1'b1, exp_mode, 1'b1, 5'b0};
      HH_PDATA: hh_rd = hh_par;
      HH_DDIR:  hh_rd = data_direction;
      HH_TXBUF: hh_rd = transmit_buffer;
      HH_RXBUF: hh_rd = receive_buffer;
      HH_SCTRL: hh_rd = serial_control;
      default:  hh_rd = BYTE_ONES;
    endcase
  end

  assign phase_new = exp_mode ? ~lvl(pin_control, 2'd1, exp_mode) : ~paddle_phase;

  always_comb begin
    port_rd = BYTE_ONES;
    if (!item.port_offset[0]) begin
      if (is_gg) begin
        port_rd[7:6] = hh_par[1:0];
      end else begin
        port_rd[7:6] = ~item.pad_two[1:0];
      end
      if (is_sms && cfg.paddle_enable) begin
        port_rd[4] = ~item.pad_one[4];
        if (phase_new) begin
          port_rd[5]   = 1'b0;
          port_rd[3:0] = item.paddle_position[3:0];
        end else begin
          port_rd[3:0] = item.paddle_position[7:4];
        end
      end else begin
        port_rd[4:0] = ~item.pad_one[4:0];
        port_rd[5]   = pin_control[0] ? ~item.pad_one[5] : (exp_mode & pin_control[4]);
      end
    end else begin
      if (is_gg) begin
        port_rd = {hh_par[6], 3'b111, hh_par[5:2]};
      end else begin
        port_rd[2:0] = ~item.pad_two[4:2];
        port_rd[3]   = pin_control[2] ? ~item.pad_two[5] : (exp_mode & pin_control[6]);
        port_rd[7]   = pin_control[3] | (exp_mode & pin_control[7]);
        port_rd[4]   = ~item.system_keys[0];
      end
      if (!is_gg && !is_sms) port_rd[5] = 1'b0;
      if (!pin_control[1]) port_rd[6] = exp_mode & pin_control[5];
    end
  end

  always_comb begin
    result               = '0;
    pin_control_next     = pin_control;
    paddle_phase_next    = paddle_phase;
    parallel_data_next   = parallel_data;
    data_direction_next  = data_direction;
    transmit_buffer_next = transmit_buffer;
    serial_control_next  = serial_control;
    unique case (item.opcode)
      OP_CTRL_WR: begin
        result.th_rising =
          (!lvl(pin_control, 2'd1, exp_mode) && lvl(item.write_data, 2'd1, exp_mode)) ||
          (!lvl(pin_control, 2'd3, exp_mode) && lvl(item.write_data, 2'd3, exp_mode));
        pin_control_next = item.write_data;
      end
      OP_PORT_RD: begin
        if (item.io_disabled) begin
          result.read_data = item.open_bus_byte;
        end else begin
          result.read_data = port_rd;
          if (!item.port_offset[0] && is_sms && cfg.paddle_enable) begin
            paddle_phase_next = phase_new;
          end
        end
      end
      OP_HH_RD: begin
        result.read_data = hh_rd;
        if (item.port_offset == HH_INPUT) begin
          if (item.system_keys[1]) result.read_data[7] = 1'b0;
          if (cfg.ntsc_display)    result.read_data[5] = 1'b0;
        end
      end
      OP_HH_WR: begin
        unique case (item.port_offset)
          HH_PDATA:  parallel_data_next   = item.write_data;
          HH_DDIR:   data_direction_next  = item.write_data;
          HH_TXBUF:  transmit_buffer_next = item.write_data;
          HH_SCTRL:  serial_control_next  = item.write_data & SCTRL_MASK;
          HH_STEREO: begin
            result.stereo_write = 1'b1;
            result.stereo_value = item.write_data;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_control     <= PIN_CONTROL_RST;
      paddle_phase    <= 1'b0;
      parallel_data   <= PDATA_RST;
      data_direction  <= DDIR_RST;
      transmit_buffer <= TXBUF_RST;
      receive_buffer  <= RXBUF_RST;
      serial_control  <= SCTRL_RST;
    end else if (commit) begin
      pin_control     <= pin_control_next;
      paddle_phase    <= paddle_phase_next;
      parallel_data   <= parallel_data_next;
      data_direction  <= data_direction_next;
      transmit_buffer <= transmit_buffer_next;
      serial_control  <= serial_control_next;
    end
  end

endmodule

// ----- rtl/console_io_port_controller_core.sv -----
// ----------------------------------------------------------------------------
// console_io_port_controller_core
// Console I/O chip: pin control, controller port reads, handheld registers.
// ----------------------------------------------------------------------------
// in_ch carries one bus access per transfer (control write, port read,
// handheld register read or write) together with the live pad, key and
// paddle inputs; out_ch returns one result per access, in order.
// The APB port sets territory, console kind, paddle and display mode;
// write it only while no access is in flight. pready is always high.
// An accepted access is held in an input register, resolved against the
// pin and handheld state by combinational logic, and lands in the result
// register; one access per cycle is sustained while out_ch takes results.
// The next access is taken while a result waits; when out_ch stalls, one
// more access is held in the input register and in_ch.ready then drops
// until the result is taken.
// Reset empties both registers and returns pins, paddle phase and the
// handheld registers to their power-on values.
// ----------------------------------------------------------------------------
module console_io_port_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cioc_in_if.sink     in_ch,
  cioc_out_if.source  out_ch
);
  import cioc_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  out_item_t result;
  out_item_t out_item;
  logic      out_valid;
  logic      advance;

  cioc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.opcode          <= opcode_t'(in_ch.opcode);
      s1_item.port_offset     <= in_ch.port_offset;
      s1_item.write_data      <= in_ch.write_data;
      s1_item.pad_one         <= in_ch.pad_one;
      s1_item.pad_two         <= in_ch.pad_two;
      s1_item.system_keys     <= in_ch.system_keys;
      s1_item.paddle_position <= in_ch.paddle_position;
      s1_item.io_disabled     <= in_ch.io_disabled;
      s1_item.open_bus_byte   <= in_ch.open_bus_byte;
    end
  end

  cioc_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .commit (s1_valid && advance),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_item <= result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.read_data    = out_item.read_data;
  assign out_ch.th_rising    = out_item.th_rising;
  assign out_ch.stereo_write = out_item.stereo_write;
  assign out_ch.stereo_value = out_item.stereo_value;

endmodule

// ----- rtl/cioc_checker.sv -----
// ----------------------------------------------------------------------------
// cioc_checker
// Port-level checks on the console I/O port controller, bound to the core.
// ----------------------------------------------------------------------------
module cioc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       th_rising,
  input logic       stereo_write,
  input logic [7:0] stereo_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(th_rising) && $stable(stereo_write) && $stable(stereo_value))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stereo_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stereo_write |-> stereo_value == 8'd0)
    else $error("stereo value without strobe");

  a_write_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (th_rising || stereo_write) |-> read_data == 8'd0 &&
      !(th_rising && stereo_write))
    else $error("write result carries read data or two strobes");

endmodule

bind console_io_port_controller_core cioc_checker u_cioc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_data    (out_ch.read_data),
  .th_rising    (out_ch.th_rising),
  .stereo_write (out_ch.stereo_write),
  .stereo_value (out_ch.stereo_value)
);
